// ----- rtl/core/lmcs_pkg.sv -----
package lmcs_pkg;

	localparam int LMCS_COLUMNS   = 16;
	localparam int LMCS_SCAN_BITS = 32;
	localparam int LMCS_CNT_W     = $clog2(LMCS_SCAN_BITS);

	// item kinds
	localparam logic [1:0] KIND_STORE = 2'd0;
	localparam logic [1:0] KIND_SCAN  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] column;
		logic [7:0] row_bits;
	} item_t;

	typedef struct packed {
		logic serial_bit;
		logic last_bit;
		logic frame_ready;
	} result_t;

	typedef enum logic {
		ST_IDLE,
		ST_SHIFT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic write;
		logic clear;
		logic shift;
	} cmd_t;

	// interleaved one-hot column select
	function automatic logic [7:0] select_onehot(input logic [2:0] idx);
		logic [7:0] sel;
		case (idx)
			3'd0: sel = 8'b0000_1000;
			3'd1: sel = 8'b0001_0000;
			3'd2: sel = 8'b0000_0100;
			3'd3: sel = 8'b0010_0000;
			3'd4: sel = 8'b0000_0010;
			3'd5: sel = 8'b0100_0000;
			3'd6: sel = 8'b0000_0001;
			3'd7: sel = 8'b1000_0000;
			default: sel = 8'b0000_0000;
		endcase
		return sel;
	endfunction

endpackage

// ----- rtl/core/lmcs_ctrl.sv -----
module lmcs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        kind,
	output logic              busy,
	output logic              strobe,
	output logic              last,
	output lmcs_pkg::cmd_t    cmd
);
	import lmcs_pkg::*;

	state_t                  state_q;
	state_t                  state_nxt;
	logic [LMCS_CNT_W-1:0]   count_q;
	logic                    accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) begin
				count_q <= '0;
			end else if (state_q == ST_SHIFT) begin
				count_q <= count_q + LMCS_CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) state_nxt = ST_SHIFT;
			end
			ST_SHIFT: begin
				// a scan taken on the last bit follows straight on
				if (last && !cmd.load) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		last      = (state_q == ST_SHIFT) && (count_q == LMCS_CNT_W'(LMCS_SCAN_BITS - 1));
		strobe    = (state_q == ST_SHIFT);
		busy      = (state_q == ST_SHIFT) && !last;
		accept    = start && !busy;
		cmd.load  = accept && (kind == KIND_SCAN);
		cmd.write = accept && (kind == KIND_STORE);
		cmd.clear = accept && (kind == KIND_CLEAR);
		cmd.shift = (state_q == ST_SHIFT);
	end

	a_scan_starts_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_SHIFT) && (count_q == '0))
		else $error("scan accepted but shift did not start at bit zero");

	a_end_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(last && !cmd.load) |=> (state_q == ST_IDLE))
		else $error("shift ran past the last bit");

	a_shift_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |=> strobe && (count_q == $past(count_q) + LMCS_CNT_W'(1)))
		else $error("bit counter skipped or shift stopped early");

endmodule

// ----- rtl/core/lmcs_dp.sv -----
module lmcs_dp #(
	parameter int COLUMNS = lmcs_pkg::LMCS_COLUMNS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lmcs_pkg::cmd_t    cmd,
	input  logic [3:0]        column,
	input  logic [7:0]        row_bits,
	input  logic              last,
	output logic              serial_bit,
	output logic              frame_ready
);
	import lmcs_pkg::*;

	localparam int IDX_W = $clog2(COLUMNS);

	logic [7:0]          store_q [COLUMNS];
	logic [COLUMNS-1:0]  valid_q;
	logic [31:0]         shreg_q;
	logic                ready_q;
	logic [IDX_W-1:0]    idx;
	logic [7:0]          stored;
	logic [7:0]          sel;
	logic [31:0]         word;

	assign idx = column[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.write) store_q[idx] <= row_bits;
	end

	// cleared entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ready_q <= 1'b1;
		end else begin
			if (cmd.clear) begin
				valid_q <= '0;
			end else if (cmd.write) begin
				valid_q[idx] <= 1'b1;
			end
			if (cmd.load) ready_q <= (idx == IDX_W'(COLUMNS - 1));
		end
	end

	always_comb begin
		stored = valid_q[idx] ? store_q[idx] : 8'h00;
		sel    = select_onehot(column[2:0]);
		// bytes out lsb first: zero, column data, low select, high select
		word   = {column[3] ? sel : 8'h00, column[3] ? 8'h00 : sel, stored, 8'h00};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			shreg_q <= word;
		end else if (cmd.shift) begin
			shreg_q <= {1'b0, shreg_q[31:1]};
		end
	end

	assign serial_bit  = shreg_q[0];
	assign frame_ready = last && ready_q;

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (valid_q == '0))
		else $error("clear left valid entries");

	a_ready_tracks_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (ready_q == ($past(idx) == IDX_W'(COLUMNS - 1))))
		else $error("frame ready does not follow scanned column");

	a_scan_leads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (serial_bit == 1'b0))
		else $error("first scan bit not zero");

endmodule

// ----- rtl/core/led_matrix_column_scan_shifter.sv -----
// channel  | ports                      | handshake
// ---------+----------------------------+------------------------------------
// item     | item (kind,column,row_bits)| taken when start high and busy low
// result   | result (serial_bit,        | one word per cycle while strobe is
//          |   last_bit, frame_ready)   | high, no back-pressure
//
// store and clear items never make the block busy; a scan gives 32 words,
// one bit per cycle from a 32-bit shift register, paced by a 5-bit counter.
// busy drops during the last bit, so scans can run back to back.
// arst_n clears the frame store (per-column valid bits) and sets frame ready.
// the receiver cannot stall: every strobed word is taken in its cycle.
module led_matrix_column_scan_shifter #(
	parameter int COLUMNS = lmcs_pkg::LMCS_COLUMNS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  lmcs_pkg::item_t    item,
	output logic               strobe,
	output lmcs_pkg::result_t  result
);
	import lmcs_pkg::*;

	cmd_t cmd;
	logic last;
	logic serial_bit;
	logic frame_ready;

	lmcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (item.kind),
		.busy   (busy),
		.strobe (strobe),
		.last   (last),
		.cmd    (cmd)
	);

	lmcs_dp #(
		.COLUMNS (COLUMNS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.column      (item.column),
		.row_bits    (item.row_bits),
		.last        (last),
		.serial_bit  (serial_bit),
		.frame_ready (frame_ready)
	);

	assign result.serial_bit  = serial_bit;
	assign result.last_bit    = last;
	assign result.frame_ready = frame_ready;

endmodule

// ----- tb/scan_checker.sv -----
`timescale 1ns / 100ps

module scan_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  lmcs_pkg::item_t   item,
	input  logic              strobe,
	input  lmcs_pkg::result_t result,
	output int                pending,
	output int                errors
);
	import lmcs_pkg::*;

	localparam logic [3:0] LAST_COL = 4'd15;
	localparam int         REPORT_MAX = 10;

	// select byte per low three column bits, interleaved one-hot
	localparam logic [7:0] COL_SELECT [8] = '{
		8'h08, 8'h10, 8'h04, 8'h20, 8'h02, 8'h40, 8'h01, 8'h80
	};

	logic [7:0] frame_cols [LMCS_COLUMNS];
	logic       frame_ready_flag;
	result_t    bits_due [$];
	int         mismatches;

	function automatic void predict_item(input item_t w);
		logic [31:0] scan_bits;
		logic [7:0]  sel;
		result_t     r;
		case (w.kind)
			KIND_STORE: frame_cols[w.column] = w.row_bits;
			KIND_CLEAR: foreach (frame_cols[i]) frame_cols[i] = 8'h00;
			KIND_SCAN: begin
				frame_ready_flag = 1'b0;
				sel = COL_SELECT[w.column[2:0]];
				// byte order on the wire: zero, data, select low, select high
				scan_bits = {w.column[3] ? sel : 8'h00, w.column[3] ? 8'h00 : sel,
					frame_cols[w.column], 8'h00};
				if (w.column == LAST_COL)
					frame_ready_flag = 1'b1;
				for (int i = 0; i < LMCS_SCAN_BITS; i++) begin
					r.serial_bit  = scan_bits[i];
					r.last_bit    = (i == LMCS_SCAN_BITS - 1);
					r.frame_ready = (i == LMCS_SCAN_BITS - 1) ? frame_ready_flag : 1'b0;
					bits_due.push_back(r);
				end
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			foreach (frame_cols[i]) frame_cols[i] = 8'h00;
			frame_ready_flag = 1'b1;
			bits_due.delete();
			mismatches = 0;
		end else begin
			if (strobe !== 1'b0) begin
				if (bits_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("unexpected word: bit=%b last=%b ready=%b",
							result.serial_bit, result.last_bit, result.frame_ready);
				end else begin
					want = bits_due.pop_front();
					if (strobe !== 1'b1 || result.serial_bit !== want.serial_bit ||
							result.last_bit !== want.last_bit ||
							result.frame_ready !== want.frame_ready) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display({"mismatch: expected bit=%b last=%b ready=%b,",
								" got bit=%b last=%b ready=%b"},
								want.serial_bit, want.last_bit, want.frame_ready,
								result.serial_bit, result.last_bit, result.frame_ready);
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				predict_item(item);
		end
		pending <= bits_due.size();
		errors  <= mismatches;
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import lmcs_pkg::*;

	localparam logic [1:0] KIND_UNUSED  = 2'd3;
	localparam int         RANDOM_ITEMS = 255;
	localparam int         PHASE_LEN    = 64;
	localparam int         CYCLE_LIMIT  = 200_000;
	localparam int         TAIL_CYCLES  = 40;
	localparam int         ITEM_W       = $bits(item_t);

	// sender idle percentage per phase
	localparam int PHASE_IDLE [4] = '{0, 52, 27, 0};

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    strobe;
	result_t result;
	int      pending;
	int      errors;
	int      taken;
	int      cycles;

	led_matrix_column_scan_shifter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	scan_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.strobe  (strobe),
		.result  (result),
		.pending (pending),
		.errors  (errors)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_item(input logic [1:0] kind, input logic [3:0] col,
			input logic [7:0] rows, input int idle_pct);
		int gap;
		item_t w;
		w.kind     = kind;
		w.column   = col;
		w.row_bits = rows;
		if ($urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 6);
			// junk on the bus while start is low must be ignored
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
				item  <= item_t'(ITEM_W'($urandom));
			end
		end
		@(negedge clk);
		start <= 1'b1;
		item  <= w;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		if (kind != KIND_UNUSED)
			taken++;
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int r;
		int idle_pct;
		int phase;
		int last_phase;
		cycles = 0;
		taken  = 0;
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty frame, extremes, both select halves, ignored kind, clear
		send_item(KIND_SCAN,   4'd15, 8'h00, 0);
		send_item(KIND_SCAN,   4'd0,  8'h00, 0);
		send_item(KIND_STORE,  4'd0,  8'hFF, 0);
		send_item(KIND_STORE,  4'd15, 8'h80, 0);
		send_item(KIND_STORE,  4'd7,  8'h01, 0);
		send_item(KIND_STORE,  4'd8,  8'hAA, 0);
		send_item(KIND_SCAN,   4'd0,  8'h00, 0);
		send_item(KIND_SCAN,   4'd7,  8'h00, 0);
		send_item(KIND_SCAN,   4'd8,  8'hFF, 0);
		send_item(KIND_SCAN,   4'd15, 8'hFF, 0);
		send_item(KIND_UNUSED, 4'd0,  8'hFF, 0);
		send_item(KIND_SCAN,   4'd0,  8'h00, 0);
		send_item(KIND_UNUSED, 4'd15, 8'h5A, 0);
		send_item(KIND_SCAN,   4'd15, 8'h00, 0);
		send_item(KIND_CLEAR,  4'd15, 8'hFF, 0);
		send_item(KIND_SCAN,   4'd0,  8'h00, 0);
		send_item(KIND_SCAN,   4'd15, 8'h00, 0);
		send_item(KIND_STORE,  4'd3,  8'h55, 0);
		send_item(KIND_SCAN,   4'd3,  8'h00, 0);
		send_item(KIND_STORE,  4'd12, 8'h00, 0);
		send_item(KIND_SCAN,   4'd12, 8'h00, 0);
		drain();

		taken = 0;
		last_phase = 0;
		while (taken < RANDOM_ITEMS) begin
			phase = (taken / PHASE_LEN) % 4;
			if (phase != last_phase)
				drain();
			last_phase = phase;
			idle_pct = PHASE_IDLE[phase];
			r = $urandom_range(0, 99);
			if (r < 15) begin
				// whole frame: optional column refresh, then scan through the last column
				for (int c = 0; c < LMCS_COLUMNS; c++) begin
					if ($urandom_range(0, 1))
						send_item(KIND_STORE, 4'(c), 8'($urandom), idle_pct);
					send_item(KIND_SCAN, 4'(c), 8'($urandom), idle_pct);
				end
			end else if (r < 50)
				send_item(KIND_STORE, 4'($urandom), 8'($urandom), idle_pct);
			else if (r < 90)
				send_item(KIND_SCAN, 4'($urandom), 8'($urandom), idle_pct);
			else if (r < 95)
				send_item(KIND_CLEAR, 4'($urandom), 8'($urandom), idle_pct);
			else
				send_item(KIND_UNUSED, 4'($urandom), 8'($urandom), idle_pct);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- led_matrix_column_scan_shifter.f -----
rtl/core/lmcs_pkg.sv
rtl/core/lmcs_ctrl.sv
rtl/core/lmcs_dp.sv
rtl/core/led_matrix_column_scan_shifter.sv
tb/scan_checker.sv
tb/tb_top.sv
